[design/lsf_pkg.sv]
package lsf_pkg;

  // fixed field widths of the item ports
  localparam int unsigned SAMPLE_WIDTH = 16;
  localparam int unsigned OUT_W        = 48;
  localparam int unsigned POINTS_W     = 11;
  localparam int unsigned STATUS_W     = 2;

  // defaults for the top level parameters
  localparam int unsigned MAX_POINTS_DEF = 1024;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // fit status codes
  localparam logic [STATUS_W-1:0] FIT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] FIT_DEGEN = 2'd1;
  localparam logic [STATUS_W-1:0] FIT_CAP   = 2'd2;

  // operations of the shared arithmetic unit
  typedef enum logic [1:0] {
    OP_MUL_SET,
    OP_MUL_ADD,
    OP_MUL_SUB,
    OP_DIV
  } lsf_op_e;

  typedef struct packed {
    logic    go;
    lsf_op_e op;
  } lsf_cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_x;
    logic signed [SAMPLE_WIDTH-1:0] sample_y;
    logic                           last_point;
  } lsf_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0]    slope;
    logic signed [OUT_W-1:0]    intercept;
    logic        [POINTS_W-1:0] points_used;
    logic        [STATUS_W-1:0] fit_status;
  } lsf_out_t;

endpackage

[design/lsf_arith_unit.sv]
module lsf_arith_unit
  import lsf_pkg::*;
#(
  parameter int unsigned NUM_W     = 69,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lsf_cmd_t                cmd_i,
  input  logic signed [NUM_W-1:0] a_i,
  input  logic signed [NUM_W-1:0] b_i,
  output logic                    done_o,
  output logic signed [NUM_W-1:0] acc_o,
  output logic signed [OUT_W-1:0] quot_o
);

  localparam int unsigned QB    = NUM_W + FRAC_BITS;
  localparam int unsigned CW    = $clog2(QB + 1);
  localparam int unsigned ADD_W = NUM_W + 1;
  localparam int unsigned QX_W  = (QB + 1 > OUT_W + 1) ? QB + 1 : OUT_W + 1;

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_MUL  = 3'd1;
  localparam logic [2:0] U_DIV  = 3'd2;
  localparam logic [2:0] U_RND  = 3'd3;
  localparam logic [2:0] U_INC  = 3'd4;
  localparam logic [2:0] U_FIN  = 3'd5;

  logic [2:0]              state_q, state_d;
  logic                    done_q;
  logic signed [NUM_W-1:0] acc_q;
  logic [NUM_W-1:0]        a_q;
  logic [NUM_W-1:0]        b_q;
  logic [QB-1:0]           nq_q;
  logic [NUM_W-1:0]        rem_q;
  logic [CW-1:0]           cnt_q;
  logic                    neg_q;
  logic                    rnd_q;
  logic [QX_W-1:0]         qx_q;
  logic signed [OUT_W-1:0] quot_q;

  logic [NUM_W-1:0] abs_a, abs_b;
  logic [ADD_W-1:0] add_x, add_y;
  logic             add_sub;
  logic [ADD_W:0]   sum;
  logic             ge;
  logic             sat;
  logic [OUT_W-1:0] limit, mag;

  // operand magnitudes at load
  assign abs_a = a_i[NUM_W-1] ? -a_i : a_i;
  assign abs_b = b_i[NUM_W-1] ? -b_i : b_i;

  // the one shared add/subtract unit
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    unique case (state_q)
      U_MUL: begin
        add_x   = ADD_W'(acc_q);
        add_y   = {1'b0, a_q};
        add_sub = neg_q;
      end
      U_DIV: begin
        add_x   = {rem_q, nq_q[QB-1]};
        add_y   = {1'b0, a_q};
        add_sub = 1'b1;
      end
      U_RND: begin
        add_x   = {rem_q, 1'b0};
        add_y   = {1'b0, a_q};
        add_sub = 1'b1;
      end
      default: begin
        add_x   = '0;
      end
    endcase
  end

  assign sum = {1'b0, add_x} + {1'b0, add_y ^ {ADD_W{add_sub}}} + (ADD_W + 1)'(add_sub);
  assign ge  = sum[ADD_W];

  // saturate the rounded magnitude and apply the sign
  always_comb begin
    if (neg_q) begin
      sat = (|qx_q[QX_W-1:OUT_W]) | (qx_q[OUT_W-1] & (|qx_q[OUT_W-2:0]));
    end else begin
      sat = |qx_q[QX_W-1:OUT_W-1];
    end
    limit = (OUT_W'(1) << (OUT_W - 1)) - OUT_W'(!neg_q);
    mag   = sat ? limit : qx_q[OUT_W-1:0];
  end

  // sequencer of the unit
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      U_IDLE: begin
        if (cmd_i.go) begin
          state_d = (cmd_i.op == OP_DIV) ? U_DIV : U_MUL;
        end
      end
      U_MUL: begin
        if (b_q == '0) begin
          state_d = U_IDLE;
        end
      end
      U_DIV: begin
        if (cnt_q == CW'(1)) begin
          state_d = U_RND;
        end
      end
      U_RND: begin
        state_d = U_INC;
      end
      U_INC: begin
        state_d = U_FIN;
      end
      U_FIN: begin
        state_d = U_IDLE;
      end
      default: begin
        state_d = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= ((state_q == U_MUL) && (b_q == '0)) || (state_q == U_FIN);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      U_IDLE: begin
        if (cmd_i.go) begin
          if (cmd_i.op == OP_DIV) begin
            a_q   <= abs_b;
            nq_q  <= QB'(abs_a) << FRAC_BITS;
            rem_q <= '0;
            cnt_q <= CW'(QB);
            neg_q <= a_i[NUM_W-1] ^ b_i[NUM_W-1];
          end else begin
            a_q   <= abs_a;
            b_q   <= abs_b;
            neg_q <= a_i[NUM_W-1] ^ b_i[NUM_W-1] ^ (cmd_i.op == OP_MUL_SUB);
            if (cmd_i.op == OP_MUL_SET) begin
              acc_q <= '0;
            end
          end
        end
      end
      U_MUL: begin
        if (b_q != '0) begin
          if (b_q[0]) begin
            acc_q <= sum[NUM_W-1:0];
          end
          a_q <= a_q << 1;
          b_q <= b_q >> 1;
        end
      end
      U_DIV: begin
        rem_q <= ge ? sum[NUM_W-1:0] : add_x[NUM_W-1:0];
        nq_q  <= {nq_q[QB-2:0], ge};
        cnt_q <= cnt_q - CW'(1);
      end
      U_RND: begin
        rnd_q <= ge;
      end
      U_INC: begin
        qx_q <= QX_W'(nq_q) + QX_W'(rnd_q);
      end
      U_FIN: begin
        quot_q <= neg_q ? -mag : mag;
      end
      default: begin
        rnd_q <= 1'b0;
      end
    endcase
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;
  assign quot_o = quot_q;

endmodule

[design/least_squares_line_fit_unit.sv]
// non-last point: accepted in any cycle busy is low, taken in at once (1 item per cycle)
// last point: busy for the fit, six multiply steps and two divisions (a zero denominator after
//   the second multiply step ends it early as degenerate), run on the bit-serial shared
//   add/subtract unit; the result shows one cycle on done_o
// the receiver cannot stall; done_o is a single-cycle strobe with busy already low
// reset (rst_ni low, asynchronous) clears the point count, the sums and both sequencers
module least_squares_line_fit_unit
  import lsf_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  lsf_in_t  in_i,
  output logic     done_o,
  output lsf_out_t result_o
);

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned SX_W  = SW + CNT_W;
  localparam int unsigned SXX_W = 2 * SW - 1 + CNT_W;
  localparam int unsigned NUM_W = 3 * SW - 1 + 2 * CNT_W;

  localparam logic [1:0] T_IDLE  = 2'd0;
  localparam logic [1:0] T_ISSUE = 2'd1;
  localparam logic [1:0] T_WAIT  = 2'd2;

  localparam logic [2:0] STEP_DEN_SET = 3'd0;
  localparam logic [2:0] STEP_DEN_SUB = 3'd1;
  localparam logic [2:0] STEP_NK_SET  = 3'd2;
  localparam logic [2:0] STEP_NK_SUB  = 3'd3;
  localparam logic [2:0] STEP_NB_SET  = 3'd4;
  localparam logic [2:0] STEP_NB_SUB  = 3'd5;
  localparam logic [2:0] STEP_DIV_K   = 3'd6;
  localparam logic [2:0] STEP_DIV_B   = 3'd7;

  logic [1:0]              state_q;
  logic [2:0]              step_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [SX_W-1:0]  sx_q, sy_q;
  logic signed [SXX_W-1:0] sxx_q, sxy_q;
  logic                    ovf_q;
  logic                    done_q;
  lsf_out_t                result_q;
  logic signed [NUM_W-1:0] den_q, nk_q, nb_q;
  logic signed [OUT_W-1:0] slope_q;

  logic                       accept;
  logic signed [2*SW-1:0]     prod_xx, prod_xy;
  lsf_cmd_t                   cmd;
  logic signed [NUM_W-1:0]    a_op, b_op;
  logic                       u_done;
  logic signed [NUM_W-1:0]    u_acc;
  logic signed [OUT_W-1:0]    u_quot;
  logic                       degen, finish;

  assign accept  = start && !busy;
  assign prod_xx = in_i.sample_x * in_i.sample_x;
  assign prod_xy = in_i.sample_x * in_i.sample_y;

  assign degen  = (step_q == STEP_DEN_SUB) && (u_acc == '0);
  assign finish = (state_q == T_WAIT) && u_done && (degen || (step_q == STEP_DIV_B));

  // operand selection for each step of the fit
  always_comb begin
    cmd.go = (state_q == T_ISSUE);
    unique case (step_q)
      STEP_DEN_SET: begin
        cmd.op = OP_MUL_SET;
        a_op   = NUM_W'(sxx_q);
        b_op   = NUM_W'(cnt_q);
      end
      STEP_DEN_SUB: begin
        cmd.op = OP_MUL_SUB;
        a_op   = NUM_W'(sx_q);
        b_op   = NUM_W'(sx_q);
      end
      STEP_NK_SET: begin
        cmd.op = OP_MUL_SET;
        a_op   = NUM_W'(sxy_q);
        b_op   = NUM_W'(cnt_q);
      end
      STEP_NK_SUB: begin
        cmd.op = OP_MUL_SUB;
        a_op   = NUM_W'(sx_q);
        b_op   = NUM_W'(sy_q);
      end
      STEP_NB_SET: begin
        cmd.op = OP_MUL_SET;
        a_op   = NUM_W'(sxx_q);
        b_op   = NUM_W'(sy_q);
      end
      STEP_NB_SUB: begin
        cmd.op = OP_MUL_SUB;
        a_op   = NUM_W'(sxy_q);
        b_op   = NUM_W'(sx_q);
      end
      STEP_DIV_K: begin
        cmd.op = OP_DIV;
        a_op   = nk_q;
        b_op   = den_q;
      end
      STEP_DIV_B: begin
        cmd.op = OP_DIV;
        a_op   = nb_q;
        b_op   = den_q;
      end
      default: begin
        cmd.op = OP_MUL_SET;
        a_op   = '0;
        b_op   = '0;
      end
    endcase
  end

  lsf_arith_unit #(
    .NUM_W    (NUM_W),
    .FRAC_BITS(FRAC_BITS)
  ) u_arith (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .a_i   (a_op),
    .b_i   (b_op),
    .done_o(u_done),
    .acc_o (u_acc),
    .quot_o(u_quot)
  );

  // point accumulation and fit sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      step_q  <= STEP_DEN_SET;
      cnt_q   <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      sxx_q   <= '0;
      sxy_q   <= '0;
      ovf_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= finish;
      if (accept) begin
        if (cnt_q < CNT_W'(MAX_POINTS)) begin
          cnt_q <= cnt_q + CNT_W'(1);
          sx_q  <= sx_q + SX_W'(in_i.sample_x);
          sy_q  <= sy_q + SX_W'(in_i.sample_y);
          sxx_q <= sxx_q + SXX_W'(prod_xx);
          sxy_q <= sxy_q + SXX_W'(prod_xy);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      unique case (state_q)
        T_IDLE: begin
          if (accept && in_i.last_point) begin
            state_q <= T_ISSUE;
            step_q  <= STEP_DEN_SET;
          end
        end
        T_ISSUE: begin
          state_q <= T_WAIT;
        end
        T_WAIT: begin
          if (finish) begin
            state_q <= T_IDLE;
            cnt_q   <= '0;
            sx_q    <= '0;
            sy_q    <= '0;
            sxx_q   <= '0;
            sxy_q   <= '0;
            ovf_q   <= 1'b0;
          end else if (u_done) begin
            state_q <= T_ISSUE;
            step_q  <= step_q + 3'd1;
          end
        end
        default: begin
          state_q <= T_IDLE;
        end
      endcase
    end
  end

  // captured intermediate values and the result item
  always_ff @(posedge clk_i) begin
    if ((state_q == T_WAIT) && u_done) begin
      case (step_q)
        STEP_DEN_SUB: den_q <= u_acc;
        STEP_NK_SUB:  nk_q <= u_acc;
        STEP_NB_SUB:  nb_q <= u_acc;
        STEP_DIV_K:   slope_q <= u_quot;
        default:      ;
      endcase
    end
    if (finish) begin
      result_q.points_used <= POINTS_W'(cnt_q);
      if (degen) begin
        result_q.slope      <= '0;
        result_q.intercept  <= '0;
        result_q.fit_status <= FIT_DEGEN;
      end else begin
        result_q.slope      <= slope_q;
        result_q.intercept  <= u_quot;
        result_q.fit_status <= ovf_q ? FIT_CAP : FIT_OK;
      end
    end
  end

  assign busy     = (state_q != T_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

[design/lsf_checker.sv]
module lsf_checker
  import lsf_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input lsf_in_t  in_i,
  input logic     done_o,
  input lsf_out_t result_o
);

  // a fit result never comes in two consecutive cycles
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // the result shows with the block already free for the next item
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  // the last point of a set starts the fit
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_i.last_point) |=> busy)
    else $error("last point did not start the fit");

  // an ordinary point is taken in without stalling the source
  a_plain_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !in_i.last_point) |=> (!busy && !done_o))
    else $error("ordinary point stalled the block or gave a result");

  // a degenerate fit reports zero slope and intercept
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.fit_status == FIT_DEGEN)) |->
      ((result_o.slope == '0) && (result_o.intercept == '0)))
    else $error("degenerate fit with nonzero outputs");

endmodule

bind least_squares_line_fit_unit lsf_checker u_lsf_checker (.*);

[sim/least_squares_line_fit_unit_tb.sv]
`timescale 1ns / 100ps

module least_squares_line_fit_unit_tb;
  import lsf_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 3_000_000;
  localparam int unsigned DRAIN_CYCLES = 500;
  localparam int unsigned RANDOM_ITEMS = 150;

  // one queued point with its sender behavior
  typedef struct {
    lsf_in_t     pt;
    int unsigned idle_pct;
    bit          drain;
  } pend_point_t;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  logic     busy;
  lsf_in_t  in_i   = '0;
  logic     done_o;
  lsf_out_t result_o;

  pend_point_t point_q[$];
  lsf_out_t    fit_q[$];
  pend_point_t cur;

  // running sums of the fit predictor
  int unsigned pt_cnt;
  longint      acc_x, acc_y, acc_xx, acc_xy;
  bit          cap_hit;

  int unsigned err_cnt, cyc_cnt, n_points, n_fits, n_degen, n_cap, n_ok;

  least_squares_line_fit_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .in_i    (in_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  // clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // rounded and saturated (num * 2^FRAC_BITS) / den, den nonzero
  function automatic logic [OUT_W-1:0] fixed_div(input logic signed [127:0] num,
                                                 input logic signed [127:0] den);
    logic         neg;
    logic [127:0] n_mag, d_mag, quo, rem, lim;
    neg   = num[127] ^ den[127];
    n_mag = num[127] ? -num : num;
    d_mag = den[127] ? -den : den;
    n_mag = n_mag << FRAC_BITS_DEF;
    quo   = n_mag / d_mag;
    rem   = n_mag % d_mag;
    // round to nearest, ties away from zero
    if ((rem << 1) >= d_mag) quo = quo + 1;
    lim = (128'd1 << (OUT_W - 1)) - (neg ? 128'd0 : 128'd1);
    if (quo > lim) quo = lim;
    if (neg) quo = -quo;
    return quo[OUT_W-1:0];
  endfunction

  function automatic void clear_sums();
    pt_cnt  = 0;
    acc_x   = 0;
    acc_y   = 0;
    acc_xx  = 0;
    acc_xy  = 0;
    cap_hit = 1'b0;
  endfunction

  // take one accepted point into the sums, fit on the last one
  function automatic void take_point(input lsf_in_t p);
    longint              xs, ys;
    logic signed [127:0] w_n, w_x, w_y, w_xx, w_xy, den;
    lsf_out_t            res;
    xs = p.sample_x;
    ys = p.sample_y;
    n_points++;
    if (pt_cnt < MAX_POINTS_DEF) begin
      pt_cnt++;
      acc_x  += xs;
      acc_y  += ys;
      acc_xx += xs * xs;
      acc_xy += xs * ys;
    end else begin
      cap_hit = 1'b1;
    end
    if (!p.last_point) return;
    w_n  = pt_cnt;
    w_x  = acc_x;
    w_y  = acc_y;
    w_xx = acc_xx;
    w_xy = acc_xy;
    den  = w_n * w_xx - w_x * w_x;
    res.points_used = POINTS_W'(pt_cnt);
    if (den == 0) begin
      res.slope      = '0;
      res.intercept  = '0;
      res.fit_status = FIT_DEGEN;
      n_degen++;
    end else begin
      res.slope      = fixed_div(w_n * w_xy - w_x * w_y, den);
      res.intercept  = fixed_div(w_xx * w_y - w_x * w_xy, den);
      res.fit_status = cap_hit ? FIT_CAP : FIT_OK;
      if (cap_hit) n_cap++;
      else n_ok++;
    end
    n_fits++;
    fit_q.push_back(res);
    clear_sums();
  endfunction

  // item driver: offers the next queued point, holds it while busy
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
      in_i  <= '0;
    end else begin
      if (start && !busy) take_point(in_i);
      if (!start || !busy) begin
        if (point_q.size() != 0 && !(point_q[0].drain && fit_q.size() != 0) &&
            $urandom_range(99) >= point_q[0].idle_pct) begin
          cur = point_q.pop_front();
          start <= 1'b1;
          in_i  <= cur.pt;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  // result monitor: compares each fit with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (fit_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none actual %h", $time, result_o);
      end else begin
        check_field("slope", 64'(fit_q[0].slope), 64'(result_o.slope));
        check_field("intercept", 64'(fit_q[0].intercept), 64'(result_o.intercept));
        check_field("points_used", 64'(fit_q[0].points_used), 64'(result_o.points_used));
        check_field("fit_status", 64'(fit_q[0].fit_status), 64'(result_o.fit_status));
        void'(fit_q.pop_front());
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cyc_cnt);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic queue_point(input int x, input int y, input bit last,
                             input int unsigned idle, input bit drain);
    pend_point_t p;
    p.pt.sample_x   = 16'(x);
    p.pt.sample_y   = 16'(y);
    p.pt.last_point = last;
    p.idle_pct      = idle;
    p.drain         = drain;
    point_q.push_back(p);
  endtask

  function automatic int edge_value();
    case ($urandom_range(4))
      0:       return -32768;
      1:       return 32767;
      2:       return -1;
      3:       return 0;
      default: return 1;
    endcase
  endfunction

  // one random point set, drawn from a few shapes
  task automatic random_set(input int unsigned n, input int unsigned idle, input bit drain);
    int unsigned mode;
    int          x, y, x0, a, b;
    mode = $urandom_range(5);
    x0   = int'(16'($urandom()));
    a    = int'($urandom_range(16)) - 8;
    b    = int'($urandom_range(10000)) - 5000;
    for (int unsigned k = 0; k < n; k++) begin
      case (mode)
        0: begin
          x = $urandom();
          y = $urandom();
        end
        1: begin
          x = int'($urandom_range(16)) - 8;
          y = int'($urandom_range(16)) - 8;
        end
        2: begin
          // exact line with small slope
          x = int'($urandom_range(6000)) - 3000;
          y = a * x + b;
        end
        3: begin
          // shared x, no spread
          x = x0;
          y = $urandom();
        end
        4: begin
          x = edge_value();
          y = edge_value();
        end
        default: begin
          // tight spread near one end of the x range
          x = (a > 0) ? 32767 - int'($urandom_range(3)) : -32768 + int'($urandom_range(3));
          y = $urandom();
        end
      endcase
      queue_point(x, y, k == n - 1, idle, drain && k == 0);
    end
  endtask

  // stimulus, reset and end of run
  initial begin
    int unsigned r, n, made, idle;
    // single points and shared x
    queue_point(0, 0, 1, 32, 0);
    queue_point(-32768, 32767, 1, 32, 0);
    queue_point(5, 1, 0, 32, 0);
    queue_point(5, 9, 1, 32, 0);
    // opposite corners of the sample range
    queue_point(-32768, -32768, 0, 32, 1);
    queue_point(32767, 32767, 1, 32, 0);
    queue_point(32767, -32768, 0, 32, 0);
    queue_point(-32768, 32767, 1, 32, 0);
    // steep lines far from the origin
    queue_point(-32768, 32767, 0, 32, 0);
    queue_point(-32767, -32768, 1, 32, 0);
    queue_point(32766, -32768, 0, 32, 0);
    queue_point(32767, 32767, 1, 32, 0);
    // fractional negative slope, all-zero y
    queue_point(0, 1, 0, 32, 0);
    queue_point(1, 0, 0, 32, 0);
    queue_point(3, 0, 1, 32, 0);
    queue_point(1, 0, 0, 32, 0);
    queue_point(2, 0, 0, 32, 0);
    queue_point(3, 0, 1, 32, 0);
    // capacity exceeded with spread in x, extra points must be dropped
    queue_point(32767, 32767, 0, 0, 1);
    for (int k = 1; k < 1024; k++) queue_point(-32768, (k % 2) ? -32768 : 32767, 0, 0, 0);
    for (int k = 0; k < 6; k++) queue_point($urandom(), $urandom(), k == 5, 0, 0);
    // random sets: sender idles 32%, then 59%, then never
    made = 0;
    while (made < RANDOM_ITEMS) begin
      idle = (made < RANDOM_ITEMS / 3) ? 32 : (made < 2 * RANDOM_ITEMS / 3) ? 59 : 0;
      r = $urandom_range(99);
      n = (r < 8) ? 1 : (r < 90) ? $urandom_range(2, 12) : $urandom_range(13, 60);
      random_set(n, idle, made == 0 || $urandom_range(5) == 0);
      made += n;
    end

    clear_sums();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (point_q.size() != 0 || start || fit_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d points in %0d fits: %0d ok, %0d degenerate, %0d over capacity",
             n_points, n_fits, n_ok, n_degen, n_cap);
    $display("leftover predictions %0d, mismatches %0d", fit_q.size(), err_cnt + fit_q.size());
    if (err_cnt == 0 && fit_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
